FILE: design/deds_pkg.sv
// Shared types and constants for the end-of-stream drain sequencer.
// Used by deds_eval and decode_eos_drain_sequencer_core; no dependencies.
package deds_pkg;

  // Largest valid per-call output budget, used as the default of MAX_BUDGET.
  localparam int DEFAULT_MAX_BUDGET = 64;

  // Item actions.
  typedef enum logic [1:0] {
    ACT_SIGNAL  = 2'd0,
    ACT_BEGIN   = 2'd1,
    ACT_DEQUEUE = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  // Outcome of a signal attempt or a dequeue.
  typedef enum logic [1:0] {
    IO_OK    = 2'd0,
    IO_RETRY = 2'd1,
    IO_WFULL = 2'd2,
    IO_ERROR = 2'd3
  } io_t;

  // Output kinds.
  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_CONTROL = 2'd1,
    KIND_UNK2    = 2'd2,
    KIND_UNK3    = 2'd3
  } kind_t;

  // Drain phases.
  typedef enum logic [2:0] {
    PH_OPEN     = 3'd0,
    PH_PENDING  = 3'd1,
    PH_DRAIN    = 3'd2,
    PH_COMPLETE = 3'd3,
    PH_FAILED   = 3'd4
  } phase_t;

  // Result codes.
  typedef enum logic [2:0] {
    RC_OK       = 3'd0,
    RC_BLOCK    = 3'd1,
    RC_NEEDREL  = 3'd2,
    RC_COMPLETE = 3'd3,
    RC_FAILED   = 3'd4,
    RC_INVALID  = 3'd5,
    RC_NOTSIG   = 3'd6
  } rc_t;

  // Architectural state of the sequencer.
  typedef struct packed {
    phase_t      phase;
    logic        requested;
    logic        queued;
    logic        eos_seen;
    logic        in_call;
    logic [7:0]  budget;
    logic [7:0]  cnt_outputs;
    logic [7:0]  cnt_frames;
    logic [7:0]  cnt_controls;
    logic [31:0] tot_outputs;
    logic [31:0] tot_frames;
    logic [31:0] tot_controls;
  } deds_state_t;

  // One input item.
  typedef struct packed {
    logic [1:0] action;
    logic [1:0] io_code;
    logic [7:0] budget;
    logic       buffer_present;
    logic [1:0] output_kind;
    logic       eos_bit;
    logic       extra_flag_bits;
    logic       frame_handled_ok;
    logic       release_ok;
  } deds_item_t;

  // One result item.
  typedef struct packed {
    rc_t         result_code;
    phase_t      phase_now;
    logic [6:0]  status_bits;
    logic        call_done;
    logic [7:0]  call_outputs;
    logic [7:0]  call_frames;
    logic [7:0]  call_controls;
    logic [31:0] total_outputs;
    logic [31:0] total_frames;
    logic [31:0] total_controls;
    logic        release_request;
    logic        fail_pending_request;
  } deds_result_t;

endpackage

FILE: design/decode_eos_drain_sequencer_core.sv
// Top level of the end-of-stream drain sequencer: input register, state,
// result register. Depends on deds_pkg and deds_eval.
//
// Usage: items (signal attempt, begin progress call, dequeued output) arrive
// on the item channel (item_valid / item_stall); one result per item leaves
// on the result channel (result_valid / result_stall). A transfer happens on
// a rising edge where valid is high and stall is low.
// Order: an item transfer loads the input register; when the item advances,
// the sequencer state and the result register update together, and the
// result is presented from the result register.
// Throughput: one item per cycle sustained while result_stall is low; all
// work for an item is a single pass of shallow logic between the input and
// result registers.
// When the receiver stalls, the result register holds and the input
// register keeps one more item; item_stall rises only when both are full.
// Reset (rst, synchronous) empties both registers and returns the state to
// phase open with all flags, call counts and totals cleared.
module decode_eos_drain_sequencer_core #(
  parameter int MAX_BUDGET = deds_pkg::DEFAULT_MAX_BUDGET
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  action,
  input  logic [1:0]  io_code,
  input  logic [7:0]  budget,
  input  logic        buffer_present,
  input  logic [1:0]  output_kind,
  input  logic        eos_bit,
  input  logic        extra_flag_bits,
  input  logic        frame_handled_ok,
  input  logic        release_ok,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  result_code,
  output logic [2:0]  phase_now,
  output logic [6:0]  status_bits,
  output logic        call_done,
  output logic [7:0]  call_outputs,
  output logic [7:0]  call_frames,
  output logic [7:0]  call_controls,
  output logic [31:0] total_outputs,
  output logic [31:0] total_frames,
  output logic [31:0] total_controls,
  output logic        release_request,
  output logic        fail_pending_request
);
  import deds_pkg::*;

  logic         held_valid;
  deds_item_t   held_item;
  deds_state_t  state;
  deds_state_t  state_next;
  deds_result_t result;
  deds_result_t result_next;
  logic         advance;
  logic         item_take;

  // The held item moves on when the result register is empty or draining.
  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !advance;
  assign item_take  = item_valid && !item_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      held_item <= '{action: action, io_code: io_code, budget: budget,
                     buffer_present: buffer_present, output_kind: output_kind,
                     eos_bit: eos_bit, extra_flag_bits: extra_flag_bits,
                     frame_handled_ok: frame_handled_ok, release_ok: release_ok};
    end
  end

  // Per-item evaluation.
  deds_eval #(
    .MAX_BUDGET(MAX_BUDGET)
  ) u_eval (
    .cur (state),
    .item(held_item),
    .nxt (state_next),
    .res (result_next)
  );

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_OPEN, default: '0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign result_code          = result.result_code;
  assign phase_now            = result.phase_now;
  assign status_bits          = result.status_bits;
  assign call_done            = result.call_done;
  assign call_outputs         = result.call_outputs;
  assign call_frames          = result.call_frames;
  assign call_controls        = result.call_controls;
  assign total_outputs        = result.total_outputs;
  assign total_frames         = result.total_frames;
  assign total_controls       = result.total_controls;
  assign release_request      = result.release_request;
  assign fail_pending_request = result.fail_pending_request;

  // A call can only be open while the stream is pending or draining.
  a_call_phase: assert property (@(posedge clk) disable iff (rst)
    state.in_call |-> (state.phase == PH_PENDING || state.phase == PH_DRAIN))
    else $error("progress call open outside pending or draining phase");

  // Completion always records the end-of-stream mark.
  a_done_eos: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_COMPLETE |-> state.eos_seen)
    else $error("complete phase without end-of-stream seen");

  // An evaluated item always lands in the result register.
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid)
    else $error("evaluated item produced no result");

  // Totals change only when an item is evaluated.
  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state.tot_outputs) && $stable(state.tot_frames) &&
                 $stable(state.tot_controls))
    else $error("running totals changed without an item");

  // The input side stalls only when an item is already held.
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> held_valid)
    else $error("item stall raised with empty input register");

endmodule

FILE: design/deds_eval.sv
// Combinational evaluation of one item against the sequencer state.
// Produces the next state and the result item. Depends on deds_pkg.
module deds_eval #(
  parameter int MAX_BUDGET = deds_pkg::DEFAULT_MAX_BUDGET
) (
  input  deds_pkg::deds_state_t  cur,
  input  deds_pkg::deds_item_t   item,
  output deds_pkg::deds_state_t  nxt,
  output deds_pkg::deds_result_t res
);
  import deds_pkg::*;

  localparam logic [7:0] BudgetMax = 8'(MAX_BUDGET);

  rc_t        rc;
  logic       done;
  logic       with_counts;
  logic       rel;
  logic       failp;
  logic       sb_window;
  logic       sb_empty;
  logic       sb_budget;
  logic [7:0] outs_inc;

  assign outs_inc = cur.cnt_outputs + 8'd1;

  // Decision tree for one item; state updates follow the item's path.
  always_comb begin
    nxt         = cur;
    rc          = RC_INVALID;
    done        = 1'b0;
    with_counts = 1'b0;
    rel         = 1'b0;
    failp       = 1'b0;
    sb_window   = 1'b0;
    sb_empty    = 1'b0;
    sb_budget   = 1'b0;
    unique case (action_t'(item.action))
      ACT_SIGNAL: begin
        nxt.in_call = 1'b0;
        done        = 1'b1;
        priority if (cur.phase == PH_FAILED) begin
          rc = RC_FAILED;
        end else if (cur.phase == PH_COMPLETE) begin
          rc = RC_COMPLETE;
        end else if (cur.phase == PH_DRAIN) begin
          rc = RC_OK;
        end else begin
          nxt.requested = 1'b1;
          nxt.phase     = PH_PENDING;
          unique case (io_t'(item.io_code))
            IO_OK: begin
              nxt.queued = 1'b1;
              nxt.phase  = PH_DRAIN;
              rc         = RC_OK;
            end
            IO_RETRY: rc = RC_BLOCK;
            IO_WFULL: begin
              rc        = RC_NEEDREL;
              sb_window = 1'b1;
            end
            IO_ERROR: begin
              nxt.phase = PH_FAILED;
              rc        = RC_FAILED;
            end
            default: rc = RC_FAILED;
          endcase
        end
      end
      ACT_BEGIN: begin
        nxt.in_call = 1'b0;
        done        = 1'b1;
        priority if (item.budget == 8'd0 || item.budget > BudgetMax) begin
          rc = RC_INVALID;
        end else if (cur.phase == PH_OPEN) begin
          rc = RC_NOTSIG;
        end else if (cur.phase == PH_FAILED) begin
          rc = RC_FAILED;
        end else if (cur.phase == PH_COMPLETE) begin
          rc = RC_COMPLETE;
        end else begin
          nxt.in_call      = 1'b1;
          nxt.budget       = item.budget;
          nxt.cnt_outputs  = '0;
          nxt.cnt_frames   = '0;
          nxt.cnt_controls = '0;
          rc               = RC_OK;
          done             = 1'b0;
          with_counts      = 1'b1;
        end
      end
      ACT_DEQUEUE: begin
        if (cur.in_call) begin
          with_counts = 1'b1;
          done        = 1'b1;
          nxt.in_call = 1'b0;
          unique case (io_t'(item.io_code))
            IO_RETRY: begin
              rc       = RC_BLOCK;
              sb_empty = 1'b1;
            end
            IO_WFULL: begin
              rc        = RC_NEEDREL;
              sb_window = 1'b1;
            end
            IO_ERROR: begin
              nxt.phase = PH_FAILED;
              rc        = RC_FAILED;
            end
            default: begin
              // A real output was dequeued.
              nxt.cnt_outputs = outs_inc;
              nxt.tot_outputs = cur.tot_outputs + 32'd1;
              nxt.phase       = PH_FAILED;
              rc              = RC_FAILED;
              priority if (!item.buffer_present) begin
                rel = 1'b0;
              end else if (kind_t'(item.output_kind) == KIND_CONTROL) begin
                rel = 1'b1;
                if (item.eos_bit && !item.extra_flag_bits && item.release_ok) begin
                  nxt.cnt_controls = cur.cnt_controls + 8'd1;
                  nxt.tot_controls = cur.tot_controls + 32'd1;
                  if (cur.phase == PH_DRAIN) begin
                    nxt.eos_seen = 1'b1;
                    nxt.phase    = PH_COMPLETE;
                    rc           = RC_COMPLETE;
                    failp        = 1'b1;
                  end
                end
              end else if (kind_t'(item.output_kind) != KIND_FRAME) begin
                rel = 1'b1;
              end else if ((item.eos_bit && cur.phase != PH_DRAIN) ||
                           !item.frame_handled_ok) begin
                rel = 1'b1;
              end else begin
                nxt.cnt_frames = cur.cnt_frames + 8'd1;
                nxt.tot_frames = cur.tot_frames + 32'd1;
                priority if (item.eos_bit) begin
                  nxt.eos_seen = 1'b1;
                  nxt.phase    = PH_COMPLETE;
                  rc           = RC_COMPLETE;
                  failp        = 1'b1;
                end else if (outs_inc >= cur.budget) begin
                  nxt.phase = cur.phase;
                  rc        = RC_OK;
                  sb_budget = 1'b1;
                end else begin
                  nxt.phase   = cur.phase;
                  nxt.in_call = 1'b1;
                  rc          = RC_OK;
                  done        = 1'b0;
                end
              end
            end
          endcase
        end
      end
      default: begin
        rc = RC_INVALID;
      end
    endcase
  end

  // Result fields reflect the state after the item.
  always_comb begin
    res.result_code          = rc;
    res.phase_now            = nxt.phase;
    res.status_bits          = {sb_budget, sb_empty, sb_window, nxt.phase == PH_FAILED,
                                nxt.eos_seen, nxt.queued, nxt.requested};
    res.call_done            = done;
    res.call_outputs         = with_counts ? nxt.cnt_outputs : 8'd0;
    res.call_frames          = with_counts ? nxt.cnt_frames : 8'd0;
    res.call_controls        = with_counts ? nxt.cnt_controls : 8'd0;
    res.total_outputs        = nxt.tot_outputs;
    res.total_frames         = nxt.tot_frames;
    res.total_controls       = nxt.tot_controls;
    res.release_request      = rel;
    res.fail_pending_request = failp;
  end

endmodule
